FILE: hdl/rational_arithmetic_unit_macros.svh
// Assertion macros for the checker file of the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define RAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define RAU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hdl/rau_pkg.sv
// Package with widths, codes and controller/datapath interface types of the rational unit.
package rau_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int EFF_W = (OPERAND_WIDTH > 31) ? 31 : OPERAND_WIDTH;
  localparam int MW = EFF_W + 1;
  localparam int DW = 2 * MW;
  localparam int RES_W = 34;
  localparam int REQ_W = 4;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD = 4'd0,
    REQ_SUB = 4'd1,
    REQ_MUL = 4'd2,
    REQ_DIV = 4'd3,
    REQ_EQ  = 4'd4,
    REQ_NE  = 4'd5,
    REQ_LT  = 4'd6,
    REQ_GT  = 4'd7,
    REQ_LE  = 4'd8,
    REQ_GE  = 4'd9,
    REQ_INC = 4'd10,
    REQ_DEC = 4'd11
  } req_e;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_GCD_AB,
    DP_GCD_PQ,
    DP_DIV_GO,
    DP_EUC_NEXT,
    DP_SET_T1,
    DP_SET_T2,
    DP_SET_P,
    DP_SET_Q,
    DP_MUL,
    DP_WR_P,
    DP_WR_Q,
    DP_ACC_P,
    DP_INC,
    DP_DEC,
    DP_ERR,
    DP_CMP
  } dp_op_e;

  typedef enum logic [2:0] {
    DSRC_EUC,
    DSRC_BD,
    DSRC_AD,
    DSRC_P,
    DSRC_Q
  } div_src_e;

  typedef enum logic [1:0] {
    MA_AN,
    MA_AD,
    MA_BN
  } mul_a_e;

  typedef enum logic [1:0] {
    MB_T1,
    MB_T2,
    MB_BN,
    MB_BD
  } mul_b_e;

  typedef struct packed {
    dp_op_e           op;
    div_src_e         dsrc;
    mul_a_e           ma;
    mul_b_e           mb;
    logic [REQ_W-1:0] req;
  } dp_cmd_t;

  typedef struct packed {
    logic y_zero;
    logic bn_zero;
    logic div_done;
  } dp_stat_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISP,
    S_GAB,
    S_ETEST,
    S_EWAIT,
    S_LBD,
    S_LBDW,
    S_LAD,
    S_LADW,
    S_AM1,
    S_AW1,
    S_AM2,
    S_AACC,
    S_AM3,
    S_AW3,
    S_MM1,
    S_MW1,
    S_MM2,
    S_MW2,
    S_XM1,
    S_XW1,
    S_XM2,
    S_XW2,
    S_CEVAL,
    S_RINIT,
    S_RP,
    S_RPW,
    S_RQ,
    S_RQW,
    S_FIN
  } ctrl_state_e;

endpackage

FILE: hdl/rau_div.sv
// Iterative signed divider with truncated quotient and remainder, one bit per cycle.
module rau_div
  import rau_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [DW-1:0] dividend_i,
  input  logic signed [DW-1:0] divisor_i,
  output logic signed [DW-1:0] quot_o,
  output logic signed [DW-1:0] rem_o,
  output logic                 done_o
);

  localparam int CW = $clog2(DW);

  logic          busy_q, busy_d;
  logic          fin_q, fin_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW:0]   rem_q, rem_d;
  logic [DW-1:0] qr_q, qr_d;
  logic [DW-1:0] dmag_q, dmag_d;
  logic          negq_q, negq_d;
  logic          negr_q, negr_d;
  logic signed [DW-1:0] quot_q, quot_d;
  logic signed [DW-1:0] remo_q, remo_d;
  logic [DW:0]   trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    qr_q   <= qr_d;
    dmag_q <= dmag_d;
    negq_q <= negq_d;
    negr_q <= negr_d;
    quot_q <= quot_d;
    remo_q <= remo_d;
  end

  always_comb begin
    busy_d = busy_q;
    fin_d  = 1'b0;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    qr_d   = qr_q;
    dmag_d = dmag_q;
    negq_d = negq_q;
    negr_d = negr_q;
    quot_d = quot_q;
    remo_d = remo_q;
    trial  = {rem_q[DW-1:0], qr_q[DW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      qr_d   = dividend_i[DW-1] ? -dividend_i : dividend_i;
      dmag_d = divisor_i[DW-1] ? -divisor_i : divisor_i;
      negq_d = dividend_i[DW-1] ^ divisor_i[DW-1];
      negr_d = dividend_i[DW-1];
    end else if (busy_q) begin
      if (trial >= {1'b0, dmag_q}) begin
        rem_d = trial - {1'b0, dmag_q};
        qr_d  = {qr_q[DW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        qr_d  = {qr_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(DW - 1)) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end else if (fin_q) begin
      quot_d = negq_q ? -$signed(qr_q) : $signed(qr_q);
      remo_d = negr_q ? -$signed(rem_q[DW-1:0]) : $signed(rem_q[DW-1:0]);
      done_d = 1'b1;
    end
  end

  assign quot_o = quot_q;
  assign rem_o  = remo_q;
  assign done_o = done_q;

endmodule

FILE: hdl/rau_dp.sv
// Datapath of the rational unit: operand and working registers, shared multiplier and divider.
module rau_dp
  import rau_pkg::*;
(
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dp_cmd_t                         cmd_i,
  output dp_stat_t                        stat_o,
  input  logic signed [OPERAND_WIDTH-1:0] a_num_i,
  input  logic signed [OPERAND_WIDTH-1:0] a_den_i,
  input  logic signed [OPERAND_WIDTH-1:0] b_num_i,
  input  logic signed [OPERAND_WIDTH-1:0] b_den_i,
  output logic signed [RES_W-1:0]         res_num_o,
  output logic signed [RES_W-1:0]         res_den_o,
  output logic                            cmp_true_o,
  output logic                            div_error_o
);

  logic signed [MW-1:0] an_q, ad_q, bn_q, bd_q, t1_q, t2_q;
  logic signed [MW-1:0] an_d, ad_d, bn_d, bd_d, t1_d, t2_d;
  logic signed [DW-1:0] x_q, y_q, p_q, q_q, prod_q;
  logic signed [DW-1:0] x_d, y_d, p_d, q_d, prod_d;
  logic                 cmp_q, cmp_d, err_q, err_d;
  logic signed [MW-1:0] an_ext, ad_ext, bn_ext, bd_ext;
  logic signed [MW-1:0] ma, mb;
  logic signed [DW-1:0] div_n, div_d, quot, rem;
  logic                 div_done;

  assign an_ext = MW'($signed(a_num_i[EFF_W-1:0]));
  assign ad_ext = MW'($signed(a_den_i[EFF_W-1:0]));
  assign bn_ext = MW'($signed(b_num_i[EFF_W-1:0]));
  assign bd_ext = MW'($signed(b_den_i[EFF_W-1:0]));

  always_comb begin
    unique case (cmd_i.ma)
      MA_AN:   ma = an_q;
      MA_AD:   ma = ad_q;
      default: ma = bn_q;
    endcase
    unique case (cmd_i.mb)
      MB_T1: mb = t1_q;
      MB_T2: mb = t2_q;
      MB_BN: mb = bn_q;
      MB_BD: mb = bd_q;
    endcase
    unique case (cmd_i.dsrc)
      DSRC_EUC: div_n = x_q;
      DSRC_BD:  div_n = DW'(bd_q);
      DSRC_AD:  div_n = DW'(ad_q);
      DSRC_P:   div_n = p_q;
      default:  div_n = q_q;
    endcase
    div_d = (cmd_i.dsrc == DSRC_EUC) ? y_q : x_q;
  end

  rau_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.op == DP_DIV_GO),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .quot_o     (quot),
    .rem_o      (rem),
    .done_o     (div_done)
  );

  always_ff @(posedge clk_i) begin
    an_q   <= an_d;
    ad_q   <= ad_d;
    bn_q   <= bn_d;
    bd_q   <= bd_d;
    t1_q   <= t1_d;
    t2_q   <= t2_d;
    x_q    <= x_d;
    y_q    <= y_d;
    p_q    <= p_d;
    q_q    <= q_d;
    prod_q <= prod_d;
    cmp_q  <= cmp_d;
    err_q  <= err_d;
  end

  always_comb begin
    an_d   = an_q;
    ad_d   = ad_q;
    bn_d   = bn_q;
    bd_d   = bd_q;
    t1_d   = t1_q;
    t2_d   = t2_q;
    x_d    = x_q;
    y_d    = y_q;
    p_d    = p_q;
    q_d    = q_q;
    prod_d = prod_q;
    cmp_d  = cmp_q;
    err_d  = err_q;
    unique case (cmd_i.op)
      DP_LOAD: begin
        an_d  = an_ext;
        ad_d  = (ad_ext == '0) ? MW'(1) : ad_ext;
        bn_d  = (cmd_i.req == REQ_SUB) ? -bn_ext : bn_ext;
        bd_d  = (bd_ext == '0) ? MW'(1) : bd_ext;
        p_d   = '0;
        q_d   = DW'(1);
        cmp_d = 1'b0;
        err_d = 1'b0;
      end
      DP_GCD_AB: begin
        x_d = DW'(ad_q);
        y_d = DW'(bd_q);
      end
      DP_GCD_PQ: begin
        x_d = p_q;
        y_d = q_q;
      end
      DP_EUC_NEXT: begin
        x_d = y_q;
        y_d = rem;
      end
      DP_SET_T1: t1_d = MW'(quot);
      DP_SET_T2: t2_d = MW'(quot);
      DP_SET_P:  p_d = quot;
      DP_SET_Q:  q_d = quot;
      DP_MUL:    prod_d = DW'(ma) * DW'(mb);
      DP_WR_P:   p_d = prod_q;
      DP_WR_Q:   q_d = prod_q;
      DP_ACC_P:  p_d = p_q + prod_q;
      DP_INC: begin
        p_d = DW'(an_q) + DW'(ad_q);
        q_d = DW'(ad_q);
      end
      DP_DEC: begin
        p_d = DW'(an_q) - DW'(ad_q);
        q_d = DW'(ad_q);
      end
      DP_ERR: begin
        err_d = 1'b1;
        p_d   = '0;
        q_d   = DW'(1);
      end
      DP_CMP: begin
        case (cmd_i.req)
          REQ_EQ:  cmp_d = (p_q == q_q);
          REQ_NE:  cmp_d = (p_q != q_q);
          REQ_LT:  cmp_d = (p_q < q_q);
          REQ_GT:  cmp_d = (p_q > q_q);
          REQ_LE:  cmp_d = (p_q <= q_q);
          REQ_GE:  cmp_d = (p_q >= q_q);
          default: cmp_d = 1'b0;
        endcase
        p_d = '0;
        q_d = DW'(1);
      end
      default: begin
      end
    endcase
  end

  assign stat_o.y_zero   = (y_q == '0);
  assign stat_o.bn_zero  = (bn_q == '0);
  assign stat_o.div_done = div_done;

  assign res_num_o   = RES_W'(p_q);
  assign res_den_o   = RES_W'(q_q);
  assign cmp_true_o  = cmp_q;
  assign div_error_o = err_q;

endmodule

FILE: hdl/rau_ctrl.sv
// Controller state machine that sequences the rational unit datapath.
module rau_ctrl
  import rau_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic [REQ_W-1:0] req_type_i,
  input  dp_stat_t         stat_i,
  output dp_cmd_t          cmd_o,
  output logic             busy,
  output logic             valid_o
);

  ctrl_state_e      state_q, state_d;
  logic [REQ_W-1:0] op_q, op_d;
  logic             phase_q, phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= '0;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      phase_q <= phase_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    phase_d    = phase_q;
    cmd_o.op   = DP_NOP;
    cmd_o.dsrc = DSRC_EUC;
    cmd_o.ma   = MA_AN;
    cmd_o.mb   = MB_T1;
    cmd_o.req  = op_q;
    valid_o    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.req = req_type_i;
        if (start) begin
          cmd_o.op = DP_LOAD;
          op_d     = req_type_i;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_FIN;
        case (op_q)
          REQ_ADD, REQ_SUB: state_d = S_GAB;
          REQ_MUL:          state_d = S_MM1;
          REQ_DIV: begin
            if (stat_i.bn_zero) begin
              cmd_o.op = DP_ERR;
            end else begin
              state_d = S_XM1;
            end
          end
          REQ_EQ, REQ_NE, REQ_LT, REQ_GT, REQ_LE, REQ_GE: state_d = S_XM1;
          REQ_INC: cmd_o.op = DP_INC;
          REQ_DEC: cmd_o.op = DP_DEC;
          default: begin
          end
        endcase
      end
      S_GAB: begin
        cmd_o.op = DP_GCD_AB;
        phase_d  = 1'b0;
        state_d  = S_ETEST;
      end
      S_ETEST: begin
        if (stat_i.y_zero) begin
          state_d = phase_q ? S_RP : S_LBD;
        end else begin
          cmd_o.op = DP_DIV_GO;
          state_d  = S_EWAIT;
        end
      end
      S_EWAIT: begin
        if (stat_i.div_done) begin
          cmd_o.op = DP_EUC_NEXT;
          state_d  = S_ETEST;
        end
      end
      S_LBD: begin
        cmd_o.op   = DP_DIV_GO;
        cmd_o.dsrc = DSRC_BD;
        state_d    = S_LBDW;
      end
      S_LBDW: begin
        if (stat_i.div_done) begin
          cmd_o.op = DP_SET_T1;
          state_d  = S_LAD;
        end
      end
      S_LAD: begin
        cmd_o.op   = DP_DIV_GO;
        cmd_o.dsrc = DSRC_AD;
        state_d    = S_LADW;
      end
      S_LADW: begin
        if (stat_i.div_done) begin
          cmd_o.op = DP_SET_T2;
          state_d  = S_AM1;
        end
      end
      S_AM1: begin
        cmd_o.op = DP_MUL;
        cmd_o.ma = MA_AN;
        cmd_o.mb = MB_T1;
        state_d  = S_AW1;
      end
      S_AW1: begin
        cmd_o.op = DP_WR_P;
        state_d  = S_AM2;
      end
      S_AM2: begin
        cmd_o.op = DP_MUL;
        cmd_o.ma = MA_BN;
        cmd_o.mb = MB_T2;
        state_d  = S_AACC;
      end
      S_AACC: begin
        cmd_o.op = DP_ACC_P;
        state_d  = S_AM3;
      end
      S_AM3: begin
        cmd_o.op = DP_MUL;
        cmd_o.ma = MA_AD;
        cmd_o.mb = MB_T1;
        state_d  = S_AW3;
      end
      S_AW3: begin
        cmd_o.op = DP_WR_Q;
        state_d  = S_RINIT;
      end
      S_MM1: begin
        cmd_o.op = DP_MUL;
        cmd_o.ma = MA_AN;
        cmd_o.mb = MB_BN;
        state_d  = S_MW1;
      end
      S_MW1: begin
        cmd_o.op = DP_WR_P;
        state_d  = S_MM2;
      end
      S_MM2: begin
        cmd_o.op = DP_MUL;
        cmd_o.ma = MA_AD;
        cmd_o.mb = MB_BD;
        state_d  = S_MW2;
      end
      S_MW2: begin
        cmd_o.op = DP_WR_Q;
        state_d  = S_RINIT;
      end
      S_XM1: begin
        cmd_o.op = DP_MUL;
        cmd_o.ma = MA_AN;
        cmd_o.mb = MB_BD;
        state_d  = S_XW1;
      end
      S_XW1: begin
        cmd_o.op = DP_WR_P;
        state_d  = S_XM2;
      end
      S_XM2: begin
        cmd_o.op = DP_MUL;
        cmd_o.ma = MA_AD;
        cmd_o.mb = MB_BN;
        state_d  = S_XW2;
      end
      S_XW2: begin
        cmd_o.op = DP_WR_Q;
        state_d  = (op_q == REQ_DIV) ? S_RINIT : S_CEVAL;
      end
      S_CEVAL: begin
        cmd_o.op = DP_CMP;
        state_d  = S_FIN;
      end
      S_RINIT: begin
        cmd_o.op = DP_GCD_PQ;
        phase_d  = 1'b1;
        state_d  = S_ETEST;
      end
      S_RP: begin
        cmd_o.op   = DP_DIV_GO;
        cmd_o.dsrc = DSRC_P;
        state_d    = S_RPW;
      end
      S_RPW: begin
        if (stat_i.div_done) begin
          cmd_o.op = DP_SET_P;
          state_d  = S_RQ;
        end
      end
      S_RQ: begin
        cmd_o.op   = DP_DIV_GO;
        cmd_o.dsrc = DSRC_Q;
        state_d    = S_RQW;
      end
      S_RQW: begin
        if (stat_i.div_done) begin
          cmd_o.op = DP_SET_Q;
          state_d  = S_FIN;
        end
      end
      S_FIN: begin
        valid_o = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

FILE: hdl/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: controller and datapath.
// One operation at a time: a transfer happens when start is high and busy is low, and the
// result appears for exactly one cycle with valid_o high; the receiver cannot stall it.
// Increment, decrement, errors, unknown codes and compares do not use the divider; multiply
// and divide run the Euclid gcd on the shared divider and then divide the numerator and
// denominator by it, and add or subtract first run a gcd of both denominators as well.
// DW, the divider width, is twice the effective operand width plus two (34 at 16 bits);
// the shared divider produces one quotient bit per cycle.
module rational_arithmetic_unit
  import rau_pkg::*;
(
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [REQ_W-1:0]                req_type_i,
  input  logic signed [OPERAND_WIDTH-1:0] a_num_i,
  input  logic signed [OPERAND_WIDTH-1:0] a_den_i,
  input  logic signed [OPERAND_WIDTH-1:0] b_num_i,
  input  logic signed [OPERAND_WIDTH-1:0] b_den_i,
  output logic                            valid_o,
  output logic signed [RES_W-1:0]         res_num_o,
  output logic signed [RES_W-1:0]         res_den_o,
  output logic                            cmp_true_o,
  output logic                            div_error_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rau_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_type_i (req_type_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy       (busy),
    .valid_o    (valid_o)
  );

  rau_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .a_num_i     (a_num_i),
    .a_den_i     (a_den_i),
    .b_num_i     (b_num_i),
    .b_den_i     (b_den_i),
    .res_num_o   (res_num_o),
    .res_den_o   (res_den_o),
    .cmp_true_o  (cmp_true_o),
    .div_error_o (div_error_o)
  );

endmodule

FILE: hdl/rau_checker.sv
// Port-level checker for the rational arithmetic unit and its bind statement.
`include "rational_arithmetic_unit_macros.svh"

module rau_checker
  import rau_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start_i,
  input logic                    busy_i,
  input logic                    valid_i,
  input logic signed [RES_W-1:0] res_num_i,
  input logic signed [RES_W-1:0] res_den_i,
  input logic                    cmp_true_i,
  input logic                    div_error_i
);

  logic flagged;
  logic zero_over_one;

  assign flagged       = valid_i && (cmp_true_i || div_error_i);
  assign zero_over_one = (res_num_i == '0) && (res_den_i == RES_W'(1));

  `RAU_ASSERT_ALWAYS(a_valid_busy, valid_i |-> busy_i, "result strobe outside a busy period")
  `RAU_ASSERT(a_valid_pulse, valid_i |=> !valid_i, "result strobe longer than one cycle")
  `RAU_ASSERT(a_accept_busy, (start_i && !busy_i) |=> busy_i, "accepted transfer did not start")
  `RAU_ASSERT(a_flags_excl, valid_i |-> !(cmp_true_i && div_error_i), "both flags set")
  `RAU_ASSERT(a_flag_zero, flagged |-> zero_over_one, "flagged result is not zero over one")

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start),
  .busy_i      (busy),
  .valid_i     (valid_o),
  .res_num_i   (res_num_o),
  .res_den_i   (res_den_o),
  .cmp_true_i  (cmp_true_o),
  .div_error_i (div_error_o)
);
